>>> hw/rtl/lce_block_fingerprint_query_unit_macros.svh
// assertion helpers for the rtl files, used by lbfq_ctrl
`ifndef LCE_BLOCK_FINGERPRINT_QUERY_UNIT_MACROS_SVH
`define LCE_BLOCK_FINGERPRINT_QUERY_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// check holding in the same cycle as the trigger
`define LBFQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check holding in the cycle after the trigger
`define LBFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LBFQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define LBFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/lbfq_pkg.sv
`timescale 1ns / 1ps

package lbfq_pkg;

  localparam int IDX_W      = 13;
  localparam int SYM_W      = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int V_W        = IDX_W + 1;
  localparam int VSUM_W     = IDX_W + 2;

  localparam int LBFQ_MAX_TEXT    = 4096;
  localparam int LBFQ_SYMBOL_BITS = 8;

  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH  = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [SYM_W-1:0]  symbol;
    logic [IDX_W-1:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] extension_length;
    logic             bad_position;
  } out_item_t;

  typedef struct packed {
    logic text_write;
    logic group_write_entry;
    logic group_write_end;
    logic query_start;
    logic rd_base;
    logic v_first;
    logic v_add_block;
    logic v_inc;
    logic v_cap;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_pos;
    logic same_pos;
    logic in_range;
    logic text_eq;
    logic group_eq;
    logic end_group;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/lbfq_stream_if.sv
`timescale 1ns / 1ps

interface lbfq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/lbfq_ram.sv
`timescale 1ns / 1ps

module lbfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/lbfq_dp.sv
`timescale 1ns / 1ps

module lbfq_dp import lbfq_pkg::*; #(
  parameter int MAX_TEXT    = LBFQ_MAX_TEXT,
  parameter int SYMBOL_BITS = LBFQ_SYMBOL_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IDX_W-1:0]     cfg_data,
  input  logic                 capture,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_item_t            out_item
);

  localparam int TXT_DEPTH = MAX_TEXT;
  localparam int GRP_DEPTH = MAX_TEXT + 1;
  localparam int TAW       = $clog2(TXT_DEPTH);
  localparam int GAW       = $clog2(GRP_DEPTH);

  logic [IDX_W-1:0]  block_length_r;
  logic [IDX_W-1:0]  text_length_r;
  logic [IDX_W-1:0]  cur_group_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  j_r;
  logic [SYM_W-1:0]  sym_r;
  logic [IDX_W-1:0]  lcp_r;
  logic [V_W-1:0]    v_r;
  logic [V_W-1:0]    v_nxt;
  logic              bad_r;
  logic              bad_nxt;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_ext_r;
  logic              out_bad_r;

  logic [IDX_W-1:0]  n_eff;
  logic [IDX_W-1:0]  t_eff;
  logic [IDX_W-1:0]  far_pos;
  logic [IDX_W-1:0]  room;
  logic [IDX_W-1:0]  group_nxt;
  logic [VSUM_W-1:0] sum_i;
  logic [VSUM_W-1:0] sum_j;

  logic                   txt_we;
  logic [TAW-1:0]         txt_raddr_a;
  logic [TAW-1:0]         txt_raddr_b;
  logic [SYMBOL_BITS-1:0] txt_rdata_a;
  logic [SYMBOL_BITS-1:0] txt_rdata_b;
  logic                   grp_we;
  logic [GAW-1:0]         grp_waddr;
  logic [IDX_W-1:0]       grp_wdata;
  logic [IDX_W-1:0]       grp_rdata_a;
  logic [IDX_W-1:0]       grp_rdata_b;

  // effective text length and block length
  assign n_eff = (32'(text_length_r) > MAX_TEXT) ? IDX_W'(MAX_TEXT) : text_length_r;
  assign t_eff = (block_length_r == '0) ? IDX_W'(1) : block_length_r;

  assign sum_i   = VSUM_W'(i_r) + VSUM_W'(v_r);
  assign sum_j   = VSUM_W'(j_r) + VSUM_W'(v_r);
  assign far_pos = (i_r > j_r) ? i_r : j_r;
  assign room    = n_eff - far_pos;

  assign group_nxt = (lcp_r < t_eff) ? i_r : cur_group_r;

  assign sts.bad_pos   = (i_r >= n_eff) || (j_r >= n_eff);
  assign sts.same_pos  = (i_r == j_r);
  assign sts.in_range  = (sum_i < VSUM_W'(n_eff)) && (sum_j < VSUM_W'(n_eff));
  assign sts.text_eq   = (txt_rdata_a == txt_rdata_b);
  assign sts.group_eq  = (grp_rdata_a == grp_rdata_b);
  assign sts.end_group = (n_eff != '0) && (i_r == n_eff - IDX_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // text store
  assign txt_we      = cmd.text_write && (32'(i_r) < MAX_TEXT);
  assign txt_raddr_a = cmd.rd_base ? TAW'(i_r) : TAW'(sum_i);
  assign txt_raddr_b = cmd.rd_base ? TAW'(j_r) : TAW'(sum_j);

  lbfq_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (TXT_DEPTH)
  ) u_text_ram (
    .clk     (clk),
    .we      (txt_we),
    .waddr   (TAW'(i_r)),
    .wdata   (SYMBOL_BITS'(sym_r)),
    .raddr_a (txt_raddr_a),
    .raddr_b (txt_raddr_b),
    .rdata_a (txt_rdata_a),
    .rdata_b (txt_rdata_b)
  );

  // group table, end group entry written after the suffix entry
  always_comb begin
    grp_we    = 1'b0;
    grp_waddr = GAW'(j_r);
    grp_wdata = group_nxt;
    if (cmd.group_write_end) begin
      grp_we    = 1'b1;
      grp_waddr = GAW'(n_eff);
      grp_wdata = n_eff;
    end else if (cmd.group_write_entry) begin
      grp_we = (32'(j_r) <= MAX_TEXT);
    end
  end

  lbfq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (GRP_DEPTH)
  ) u_group_ram (
    .clk     (clk),
    .we      (grp_we),
    .waddr   (grp_waddr),
    .wdata   (grp_wdata),
    .raddr_a (GAW'(sum_i)),
    .raddr_b (GAW'(sum_j)),
    .rdata_a (grp_rdata_a),
    .rdata_b (grp_rdata_b)
  );

  // extension length register
  always_comb begin
    v_nxt   = v_r;
    bad_nxt = bad_r;
    if (cmd.query_start) begin
      bad_nxt = sts.bad_pos;
      if (sts.bad_pos) begin
        v_nxt = '0;
      end else if (sts.same_pos) begin
        v_nxt = V_W'(n_eff - i_r);
      end else begin
        v_nxt = '0;
      end
    end else if (cmd.v_first) begin
      v_nxt = sts.text_eq ? V_W'(1) : '0;
    end else if (cmd.v_add_block) begin
      v_nxt = v_r + V_W'(t_eff);
    end else if (cmd.v_inc) begin
      v_nxt = v_r + V_W'(1);
    end else if (cmd.v_cap) begin
      v_nxt = (v_r > V_W'(room)) ? V_W'(room) : v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= IDX_W'(1);
      text_length_r  <= '0;
      cur_group_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_LENGTH: block_length_r <= cfg_data;
          CFG_TEXT_LENGTH:  text_length_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.group_write_entry) begin
        cur_group_r <= group_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      i_r   <= in_item.first_index;
      j_r   <= in_item.second_index;
      sym_r <= in_item.symbol;
      lcp_r <= in_item.prefix_len;
    end
    v_r   <= v_nxt;
    bad_r <= bad_nxt;
    if (cmd.out_load) begin
      out_ext_r <= IDX_W'(v_r);
      out_bad_r <= bad_r;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_item.extension_length = out_ext_r;
  assign out_item.bad_position     = out_bad_r;

endmodule

>>> hw/rtl/lbfq_ctrl.sv
`timescale 1ns / 1ps
`include "lce_block_fingerprint_query_unit_macros.svh"

module lbfq_ctrl import lbfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  output logic              capture,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TEXT   = 4'd1;
  localparam logic [3:0] S_ENTRY  = 4'd2;
  localparam logic [3:0] S_END    = 4'd3;
  localparam logic [3:0] S_QUERY  = 4'd4;
  localparam logic [3:0] S_FIRST  = 4'd5;
  localparam logic [3:0] S_GISSUE = 4'd6;
  localparam logic [3:0] S_GCHECK = 4'd7;
  localparam logic [3:0] S_SISSUE = 4'd8;
  localparam logic [3:0] S_SCHECK = 4'd9;
  localparam logic [3:0] S_CAP    = 4'd10;
  localparam logic [3:0] S_RESULT = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    capture   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          capture = 1'b1;
          case (in_kind)
            KIND_TEXT:  state_nxt = S_TEXT;
            KIND_LOAD:  state_nxt = S_ENTRY;
            KIND_QUERY: state_nxt = S_QUERY;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_TEXT: begin
        cmd.text_write = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_ENTRY: begin
        cmd.group_write_entry = 1'b1;
        state_nxt = sts.end_group ? S_END : S_IDLE;
      end
      S_END: begin
        cmd.group_write_end = 1'b1;
        state_nxt           = S_IDLE;
      end
      S_QUERY: begin
        // first symbols are read here for the compare in the next state
        cmd.query_start = 1'b1;
        cmd.rd_base     = 1'b1;
        state_nxt = (sts.bad_pos || sts.same_pos) ? S_RESULT : S_FIRST;
      end
      S_FIRST: begin
        cmd.v_first = 1'b1;
        state_nxt   = sts.text_eq ? S_GISSUE : S_RESULT;
      end
      S_GISSUE: begin
        state_nxt = sts.in_range ? S_GCHECK : S_SISSUE;
      end
      S_GCHECK: begin
        if (sts.group_eq) begin
          cmd.v_add_block = 1'b1;
          state_nxt       = S_GISSUE;
        end else begin
          state_nxt = S_SISSUE;
        end
      end
      S_SISSUE: begin
        state_nxt = sts.in_range ? S_SCHECK : S_CAP;
      end
      S_SCHECK: begin
        if (sts.text_eq) begin
          cmd.v_inc = 1'b1;
          state_nxt = S_SISSUE;
        end else begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        cmd.v_cap = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LBFQ_ASSERT_SAME(a_load_needs_room, clk, rst_n, cmd.out_load, sts.out_free, "result loaded over a pending one")
  `LBFQ_ASSERT_SAME(a_end_after_entry, clk, rst_n, cmd.group_write_end, $past(cmd.group_write_entry), "end group without entry")
  `LBFQ_ASSERT_NEXT(a_no_load_after_req, clk, rst_n, in_valid && in_ready, !cmd.out_load, "result right after request")
  `LBFQ_ASSERT_SAME(a_one_writer, clk, rst_n, cmd.text_write, !cmd.group_write_entry && !cmd.group_write_end, "text and group write together")

endmodule

>>> hw/rtl/lce_block_fingerprint_query_unit.sv
`timescale 1ns / 1ps

// Longest common extension engine. Load the text with kind 0 requests, then the sorted
// suffixes with their LCP values in rank order with kind 1 requests, then issue kind 2
// queries; only queries return a result. A load of rank text_length-1 also writes the
// end group entry, and a request of the unused kind is dropped. A query skips the search
// and returns its result when a position is out of range, the positions are equal or
// the first symbols differ; otherwise it makes block jumps over the group table, then
// symbol steps over the text store, and then caps the length. Each step reads the group
// table or the text store (registered read) and compares before the next step. A query
// also waits while an earlier result is still unread. One request is in flight at a
// time; a finished result waits in the output register while the next request is
// accepted. Stores are not cleared at reset.
module lce_block_fingerprint_query_unit import lbfq_pkg::*; #(
  parameter int MAX_TEXT    = LBFQ_MAX_TEXT,
  parameter int SYMBOL_BITS = LBFQ_SYMBOL_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IDX_W-1:0]     cfg_data,
  lbfq_stream_if.sink          in_req,
  lbfq_stream_if.source        out_rsp
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      capture;
  logic      in_ready;
  logic      out_valid;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item = in_req.payload;

  lbfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_kind  (in_item.kind),
    .in_ready (in_ready),
    .capture  (capture),
    .cmd      (cmd),
    .sts      (sts)
  );

  lbfq_dp #(
    .MAX_TEXT    (MAX_TEXT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .capture   (capture),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_rsp.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid;
  assign out_rsp.payload = out_item;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lbfq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int CLK_HALF      = 6;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TARGET_REQS   = 1100;
  localparam int TAIL_RESERVE  = 60;
  localparam int TAIL_LEN      = 16;
  localparam int IDX_MAX       = (1 << IDX_W) - 1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IDX_W-1:0]     cfg_data;

  lbfq_stream_if #(.payload_t(in_item_t))  req_if ();
  lbfq_stream_if #(.payload_t(out_item_t)) rsp_if ();

  lce_block_fingerprint_query_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_req   (req_if),
    .out_rsp  (rsp_if)
  );

  in_item_t  pending_reqs[$];
  out_item_t expected_lce[$];

  // predictor image of the block
  logic [SYM_W-1:0] text_image [LBFQ_MAX_TEXT];
  logic [IDX_W-1:0] group_image [LBFQ_MAX_TEXT+1];
  logic [IDX_W-1:0] running_group;
  logic [IDX_W-1:0] block_len_shadow;
  logic [IDX_W-1:0] text_len_shadow;

  // text planned by the generator and its sorted suffixes
  logic [SYM_W-1:0] plan_text [LBFQ_MAX_TEXT];
  int               suffix_order [LBFQ_MAX_TEXT];
  int               suffix_lcp [LBFQ_MAX_TEXT];

  int   err_count = 0;
  int   cycle_count = 0;
  int   stim_count = 0;
  int   query_count = 0;
  int   result_count = 0;
  int   reg_write_count = 0;
  int   send_idle_pct = 23;
  int   recv_idle_pct = 23;
  logic req_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_lce.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic int extension_of(int i, int j, int n, int t);
    int v;
    int far_pos;
    far_pos = (i > j) ? i : j;
    if (i == j) return n - i;
    if (text_image[i] != text_image[j]) return 0;
    v = 1;
    while (i + v < n && j + v < n && group_image[i + v] == group_image[j + v]) v += t;
    while (i + v < n && j + v < n && text_image[i + v] == text_image[j + v]) v++;
    if (v > n - far_pos) v = n - far_pos;
    return v;
  endfunction

  task automatic apply_request(in_item_t r);
    int        n;
    int        t;
    out_item_t e;
    n = (text_len_shadow > LBFQ_MAX_TEXT) ? LBFQ_MAX_TEXT : int'(text_len_shadow);
    t = (block_len_shadow == 0) ? 1 : int'(block_len_shadow);
    case (r.kind)
      KIND_TEXT: begin
        if (r.first_index < LBFQ_MAX_TEXT) text_image[r.first_index] = r.symbol;
      end
      KIND_LOAD: begin
        if (r.prefix_len < t) running_group = r.first_index;
        if (r.second_index <= LBFQ_MAX_TEXT) group_image[r.second_index] = running_group;
        // closing rank marks the end position with its own group
        if (n >= 1 && r.first_index == n - 1) group_image[n] = IDX_W'(n);
      end
      KIND_QUERY: begin
        if (r.first_index >= n || r.second_index >= n) begin
          e.extension_length = '0;
          e.bad_position     = 1'b1;
        end else begin
          e.extension_length = IDX_W'(extension_of(r.first_index, r.second_index, n, t));
          e.bad_position     = 1'b0;
        end
        expected_lce.push_back(e);
        query_count++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    result_count++;
    if (expected_lce.size() == 0) begin
      report_mismatch("result with no query outstanding", got.extension_length, '0);
      return;
    end
    want = expected_lce.pop_front();
    if (got.extension_length !== want.extension_length)
      report_mismatch("extension_length", got.extension_length, want.extension_length);
    if (got.bad_position !== want.bad_position)
      report_mismatch("bad_position", got.bad_position, want.bad_position);
  endtask

  always @(posedge clk) begin
    req_fire = rst_n && req_if.valid && req_if.ready;
    if (req_fire) apply_request(req_if.payload);
    if (rst_n && rsp_if.valid && rsp_if.ready) check_result(rsp_if.payload);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid   <= 1'b1;
        req_if.payload <= pending_reqs.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && $urandom_range(99) >= recv_idle_pct) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= IDX_W'(value);
    if (idx == CFG_BLOCK_LENGTH) begin
      block_len_shadow = IDX_W'(value);
    end else begin
      text_len_shadow = IDX_W'(value);
    end
    reg_write_count++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain every request and result, then give the last load time to finish
  task automatic settle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_lce.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_req(logic [KIND_W-1:0] kind, int a, int b, int sym, int lcp);
    in_item_t r;
    r.kind         = kind;
    r.first_index  = IDX_W'(a);
    r.second_index = IDX_W'(b);
    r.symbol       = SYM_W'(sym);
    r.prefix_len   = IDX_W'(lcp);
    pending_reqs.push_back(r);
    if (!(kind == KIND_SPARE || (kind == KIND_TEXT && a >= LBFQ_MAX_TEXT))) stim_count++;
  endtask

  task automatic queue_query(int i, int j);
    queue_req(KIND_QUERY, i, j, $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
  endtask

  task automatic queue_text(int n);
    for (int k = 0; k < n; k++)
      queue_req(KIND_TEXT, k, $urandom_range(0, IDX_MAX), plan_text[k],
                $urandom_range(0, IDX_MAX));
  endtask

  task automatic queue_ranks(int n);
    for (int k = 0; k < n; k++)
      queue_req(KIND_LOAD, k, suffix_order[k], $urandom_range(0, 255), suffix_lcp[k]);
  endtask

  function automatic int shared_prefix(int p, int q, int n);
    int k;
    k = 0;
    while (p + k < n && q + k < n && plan_text[p + k] == plan_text[q + k]) k++;
    return k;
  endfunction

  // true when suffix p sorts after suffix q; the end of text sorts lowest
  function automatic bit suffix_after(int p, int q, int n);
    int k;
    k = shared_prefix(p, q, n);
    if (p + k == n) return 1'b0;
    if (q + k == n) return 1'b1;
    return plan_text[p + k] > plan_text[q + k];
  endfunction

  task automatic sort_suffixes(int n);
    int key;
    int m;
    for (int k = 0; k < n; k++) suffix_order[k] = k;
    for (int k = 1; k < n; k++) begin
      key = suffix_order[k];
      m = k - 1;
      while (m >= 0 && suffix_after(suffix_order[m], key, n)) begin
        suffix_order[m + 1] = suffix_order[m];
        m--;
      end
      suffix_order[m + 1] = key;
    end
    suffix_lcp[0] = 0;
    for (int k = 1; k < n; k++)
      suffix_lcp[k] = shared_prefix(suffix_order[k-1], suffix_order[k], n);
  endtask

  // mostly in-range queries, some bad positions and a little noise
  task automatic queue_mixed_request(int n);
    int roll;
    int i;
    roll = $urandom_range(99);
    if (roll < 8) begin
      case ($urandom_range(2))
        0: queue_req(KIND_SPARE, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                     $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
        1: queue_req(KIND_TEXT, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                     $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
        default: queue_req(KIND_LOAD, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                           $urandom_range(0, 255), $urandom_range(0, IDX_MAX));
      endcase
    end else if (roll < 18 || n == 0) begin
      if ($urandom_range(1)) begin
        queue_query($urandom_range(n, IDX_MAX), $urandom_range(0, IDX_MAX));
      end else begin
        queue_query($urandom_range(0, IDX_MAX), $urandom_range(n, IDX_MAX));
      end
    end else if (roll < 28) begin
      i = $urandom_range(0, n - 1);
      queue_query(i, i);
    end else begin
      queue_query($urandom_range(0, n - 1), $urandom_range(0, n - 1));
    end
  endtask

  task automatic random_phase(int n, int t, int nq, bit pause_midway);
    int alpha;
    int period;
    int base;
    settle();
    write_reg(CFG_BLOCK_LENGTH, t);
    write_reg(CFG_TEXT_LENGTH, n);
    alpha  = $urandom_range(1, 4);
    base   = $urandom_range(0, 256 - alpha);
    // periodic texts give long matches and many block jumps
    period = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : n;
    for (int k = 0; k < n; k++)
      plan_text[k] = (k < period) ? SYM_W'(base + $urandom_range(0, alpha - 1))
                                  : plan_text[k % period];
    sort_suffixes(n);
    queue_text(n);
    queue_ranks(n);
    for (int q = 0; q < nq; q++) begin
      if (pause_midway && q == nq / 2) settle();
      queue_mixed_request(n);
    end
  endtask

  initial begin
    int phase_idx;
    int t;
    int n;
    int sym;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BLOCK_LENGTH;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    running_group    = '0;
    block_len_shadow = IDX_W'(1);
    text_len_shadow  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short alternating text with the extreme symbols, zero block length
    write_reg(CFG_BLOCK_LENGTH, 0);
    write_reg(CFG_TEXT_LENGTH, 6);
    for (int k = 0; k < 6; k++) plan_text[k] = (k % 2) ? 8'hFF : 8'h00;
    sort_suffixes(6);
    queue_text(6);
    queue_ranks(6);
    queue_query(0, 0);
    queue_query(5, 5);
    queue_query(0, 1);
    queue_query(0, 2);
    queue_query(1, 3);
    queue_query(6, 0);
    queue_query(0, IDX_MAX);
    queue_req(KIND_SPARE, IDX_MAX, IDX_MAX, 255, IDX_MAX);
    queue_req(KIND_TEXT, IDX_MAX, 0, 255, 0);
    queue_req(KIND_LOAD, IDX_MAX, LBFQ_MAX_TEXT, 0, IDX_MAX);
    settle();
    write_reg(CFG_TEXT_LENGTH, 0);
    queue_query(0, 0);

    phase_idx = 0;
    while (stim_count < TARGET_REQS - TAIL_RESERVE) begin
      case (phase_idx)
        0: t = 1;
        1: t = LBFQ_MAX_TEXT;
        2: t = 0;
        default: t = ($urandom_range(0, 9) == 0) ? IDX_MAX : $urandom_range(1, 6);
      endcase
      n = ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 40);
      if (phase_idx == 3 || phase_idx == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 23;
        recv_idle_pct = 23;
      end
      random_phase(n, t, $urandom_range(20, 40), phase_idx % 3 == 1);
      phase_idx++;
    end

    // text length at the store size, only the last positions are loaded
    settle();
    write_reg(CFG_BLOCK_LENGTH, 4);
    write_reg(CFG_TEXT_LENGTH, LBFQ_MAX_TEXT);
    sym = $urandom_range(0, 255);
    for (int k = 0; k < TAIL_LEN; k++)
      queue_req(KIND_TEXT, LBFQ_MAX_TEXT - TAIL_LEN + k, 0,
                ($urandom_range(0, 3) == 0) ? (sym ^ 1) : sym, 0);
    // ranks end at text_length-1 so the end position gets its own group
    for (int k = 0; k < TAIL_LEN; k++)
      queue_req(KIND_LOAD, LBFQ_MAX_TEXT - TAIL_LEN + k, LBFQ_MAX_TEXT - 1 - k, 0, k);
    queue_query(LBFQ_MAX_TEXT - 1, 0);
    queue_query(LBFQ_MAX_TEXT - 1, LBFQ_MAX_TEXT - 1);
    queue_query(0, 0);
    queue_query(LBFQ_MAX_TEXT, 0);
    for (int q = 0; q < 12; q++)
      queue_query($urandom_range(LBFQ_MAX_TEXT - TAIL_LEN, LBFQ_MAX_TEXT - 1),
                  $urandom_range(LBFQ_MAX_TEXT - TAIL_LEN, LBFQ_MAX_TEXT - 1));

    // text length register above the store size
    settle();
    write_reg(CFG_TEXT_LENGTH, IDX_MAX);
    queue_query(LBFQ_MAX_TEXT, LBFQ_MAX_TEXT - 1);
    queue_query(0, LBFQ_MAX_TEXT - 1);
    for (int q = 0; q < 8; q++)
      queue_query($urandom_range(LBFQ_MAX_TEXT - TAIL_LEN, LBFQ_MAX_TEXT - 1),
                  $urandom_range(LBFQ_MAX_TEXT - TAIL_LEN, LBFQ_MAX_TEXT - 1));

    settle();
    $display("sent %0d requests over %0d table phases, %0d register writes", stim_count,
             phase_idx + 3, reg_write_count);
    $display("%0d queries predicted, %0d results checked, %0d mismatches", query_count,
             result_count, err_count);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lbfq_pkg.sv
hw/rtl/lbfq_stream_if.sv
hw/rtl/lbfq_ram.sv
hw/rtl/lbfq_dp.sv
hw/rtl/lbfq_ctrl.sv
hw/rtl/lce_block_fingerprint_query_unit.sv
bench/testbench.sv
